/* hw/rtl/lum_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lum_pkg
// Shared types, constants and saturating fixed-point helpers for the
// lens undistortion map.
// ----------------------------------------------------------------------------
package lum_pkg;

  // Top-level parameter defaults
  localparam int unsigned MaxImageSideDef = 4096;
  localparam int unsigned IterationsDef   = 5;

  // Divider: one quotient bit per cell, plus entry and exit registers
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DivLat   = DivSteps + 2;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_FOCAL_X     = 3'd0,
    REG_FOCAL_Y     = 3'd1,
    REG_PRINCIPAL   = 3'd2,
    REG_RADIAL_1    = 3'd3,
    REG_RADIAL_2    = 3'd4,
    REG_RADIAL_3    = 3'd5,
    REG_TANGENTIAL_1 = 3'd6,
    REG_TANGENTIAL_2 = 3'd7
  } lum_reg_e;

  // Register reset values (500.0 focal, principal point 320.0 / 240.0)
  localparam logic [31:0] FocalRst     = 32'h01F4_0000;
  localparam logic [63:0] PrincipalRst = 64'h00F0_0000_0140_0000;

  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;
  localparam logic signed [31:0] OneQ28 = 32'sh1000_0000;
  localparam logic signed [39:0] S32MaxW = 40'sd2147483647;
  localparam logic signed [39:0] S32MinW = -40'sd2147483648;

  // Distortion coefficients, Q4.28
  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } lum_coef_t;

  // Partial state of one long-division cell
  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] nb;
    logic [32:0] quo;
    logic [31:0] dvs;
    logic        neg;
    logic        ovf;
  } lum_div_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > S32MaxW) begin
      r = S32Max;
    end else if (v < S32MinW) begin
      r = S32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [39:0] s;
    s = 40'(a) + 40'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [39:0] s;
    s = 40'(a) - 40'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] dbl_sat(input logic signed [31:0] a);
    logic signed [39:0] s;
    s = 40'(a) + 40'(a);
    return sat32(s);
  endfunction

  // Q4.28 product, round half up, saturated
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [39:0] r;
    p = a * b;
    r = 40'(p >>> 28) + $signed({39'd0, p[27]});
    return sat32(r);
  endfunction

endpackage

/* hw/rtl/lum_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lum_div_cell
// One restoring long-division step: shifts in a numerator bit, produces
// one quotient bit and hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module lum_div_cell import lum_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  lum_div_t st_i,
  output logic     valid_o,
  output lum_div_t st_o
);

  logic     valid_q;
  lum_div_t st_d, st_q;
  logic [32:0] rr, diff;
  logic        ge;

  // Trial subtract of the divisor
  always_comb begin
    rr   = {st_i.rem, st_i.nb[32]};
    diff = rr - {1'b0, st_i.dvs};
    ge   = (rr >= {1'b0, st_i.dvs});
    st_d     = st_i;
    st_d.rem = ge ? diff[31:0] : rr[31:0];
    st_d.nb  = {st_i.nb[31:0], 1'b0};
    st_d.quo = {st_i.quo[31:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

/* hw/rtl/lum_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lum_divider
// Pipelined divider: num / den into a saturated signed 32-bit quotient,
// one quotient bit per cell, a new operand pair every enabled (en_i) cycle.
// ----------------------------------------------------------------------------
module lum_divider import lum_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [61:0]        num_i,
  input  logic [31:0]        den_i,
  input  logic               neg_i,
  output logic               valid_o,
  output logic signed [31:0] quo_o
);

  lum_div_t st [DivSteps+1];
  logic     vld [DivSteps+1];
  lum_div_t pre_d;
  logic [31:0] top_bits;

  // Entry: quotients of 2^33 and more saturate straight away
  always_comb begin
    top_bits  = {3'd0, num_i[61:33]};
    pre_d.ovf = (top_bits >= den_i);
    pre_d.rem = pre_d.ovf ? '0 : top_bits;
    pre_d.nb  = num_i[32:0];
    pre_d.quo = '0;
    pre_d.dvs = den_i;
    pre_d.neg = neg_i;
  end

  logic     pre_v_q;
  lum_div_t pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else if (en_i) begin
      pre_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  assign st[0]  = pre_q;
  assign vld[0] = pre_v_q;

  // Chain of division cells
  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    lum_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[i]),
      .st_i    (st[i]),
      .valid_o (vld[i+1]),
      .st_o    (st[i+1])
    );
  end

  // Exit: clip magnitude to 2^31, apply sign, saturate
  lum_div_t           fin;
  logic               sat_hi;
  logic [31:0]        qc;
  logic signed [31:0] res_d, res_q;
  logic               out_v_q;

  always_comb begin
    fin    = st[DivSteps];
    sat_hi = fin.ovf | fin.quo[32] | (fin.quo[31] & (|fin.quo[30:0]));
    qc     = sat_hi ? 32'h8000_0000 : fin.quo[31:0];
    if (fin.neg) begin
      res_d = -$signed(qc);
    end else begin
      res_d = qc[31] ? S32Max : $signed(qc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= vld[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = out_v_q;
  assign quo_o   = res_q;

endmodule

/* hw/rtl/lum_iter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lum_iter
// One undistortion iteration as a pipeline: radial polynomial, tangential
// terms, reciprocal of the radial factor and the corrected coordinates.
// ----------------------------------------------------------------------------
module lum_iter import lum_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lum_coef_t          coef_i,
  input  logic               valid_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] x0_i,
  input  logic signed [31:0] y0_i,
  output logic               valid_o,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic signed [31:0] x0_o,
  output logic signed [31:0] y0_o
);

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
  } side_t;

  logic [5:1] v_q;

  // Stage 1: squares and cross product
  logic signed [31:0] s1_xx_q, s1_yy_q, s1_xy_q, s1_x0_q, s1_y0_q;
  // Stage 2: r^2 and tangential partial terms
  logic signed [31:0] s2_r2_q, s2_tx_q, s2_ty_q, s2_a_q, s2_b_q, s2_x0_q, s2_y0_q;
  // Stage 3: first Horner step, tangential deltas
  logic signed [31:0] s3_r2_q, s3_p_q, s3_dx_q, s3_dy_q, s3_x0_q, s3_y0_q;
  // Stage 4: second Horner step, corrected numerators
  logic signed [31:0] s4_r2_q, s4_p_q;
  side_t              s4_q;
  // Stage 5: radial denominator
  logic signed [31:0] s5_den_q;
  side_t              s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_xx_q <= qmul(x_i, x_i);
      s1_yy_q <= qmul(y_i, y_i);
      s1_xy_q <= qmul(x_i, y_i);
      s1_x0_q <= x0_i;
      s1_y0_q <= y0_i;

      s2_r2_q <= add_sat(s1_xx_q, s1_yy_q);
      s2_tx_q <= add_sat(add_sat(s1_xx_q, s1_yy_q), dbl_sat(s1_xx_q));
      s2_ty_q <= add_sat(add_sat(s1_xx_q, s1_yy_q), dbl_sat(s1_yy_q));
      s2_a_q  <= dbl_sat(qmul(coef_i.p1, s1_xy_q));
      s2_b_q  <= dbl_sat(qmul(coef_i.p2, s1_xy_q));
      s2_x0_q <= s1_x0_q;
      s2_y0_q <= s1_y0_q;

      s3_r2_q <= s2_r2_q;
      s3_p_q  <= add_sat(qmul(coef_i.k3, s2_r2_q), coef_i.k2);
      s3_dx_q <= add_sat(s2_a_q, qmul(coef_i.p2, s2_tx_q));
      s3_dy_q <= add_sat(qmul(coef_i.p1, s2_ty_q), s2_b_q);
      s3_x0_q <= s2_x0_q;
      s3_y0_q <= s2_y0_q;

      s4_r2_q  <= s3_r2_q;
      s4_p_q   <= add_sat(qmul(s3_p_q, s3_r2_q), coef_i.k1);
      s4_q.ex  <= sub_sat(s3_x0_q, s3_dx_q);
      s4_q.ey  <= sub_sat(s3_y0_q, s3_dy_q);
      s4_q.x0  <= s3_x0_q;
      s4_q.y0  <= s3_y0_q;

      s5_den_q <= add_sat(OneQ28, qmul(s4_p_q, s4_r2_q));
      s5_q     <= s4_q;
    end
  end

  // Reciprocal 2^56 / den, rounded to nearest
  logic [31:0]        den_mag;
  logic [61:0]        rc_num;
  logic               rc_v;
  logic signed [31:0] ic;

  assign den_mag = s5_den_q[31] ? 32'(-s5_den_q) : 32'(s5_den_q);
  assign rc_num  = (62'd1 << 56) + 62'(den_mag[31:1]);

  lum_divider u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q[5]),
    .num_i   (rc_num),
    .den_i   (den_mag),
    .neg_i   (s5_den_q[31]),
    .valid_o (rc_v),
    .quo_o   (ic)
  );

  // Side values wait alongside the reciprocal
  side_t dly_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= s5_q;
      for (int i = 1; i < DivLat; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // Final scaling
  logic               out_v_q;
  logic signed [31:0] x_q, y_q, x0_q, y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= rc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= qmul(dly_q[DivLat-1].ex, ic);
      y_q  <= qmul(dly_q[DivLat-1].ey, ic);
      x0_q <= dly_q[DivLat-1].x0;
      y0_q <= dly_q[DivLat-1].y0;
    end
  end

  assign valid_o = out_v_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign x0_o    = x0_q;
  assign y0_o    = y0_q;

endmodule

/* hw/rtl/lens_undistort_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_undistort_map
// Maps a source pixel to its undistorted position: normalize, iterate the
// radial/tangential inverse, project back with the same intrinsics.
// Throughput: one pixel per cycle while pix_stall_o is low; each division
// is a 33-cell pipelined divider and each iteration a fixed pipeline, so
// nothing is shared.
// Reset: registers return to their defaults, pipeline empties; no clearing pass.
// ----------------------------------------------------------------------------
module lens_undistort_map import lum_pkg::*; #(
  parameter int unsigned MAX_IMAGE_SIDE = MaxImageSideDef,
  parameter int unsigned ITERATIONS     = IterationsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  // pixel transactions
  input  logic               pix_valid_i,
  output logic               pix_stall_o,
  input  logic [11:0]        pixel_col_i,
  input  logic [11:0]        pixel_row_i,
  // map transactions
  output logic               map_valid_o,
  input  logic               map_stall_i,
  output logic signed [31:0] map_col_o,
  output logic signed [31:0] map_row_o
);

  localparam logic [16:0] SideMax = 17'(MAX_IMAGE_SIDE - 1);

  // Configuration registers
  logic [31:0] fx_q, fy_q;
  logic [63:0] pp_q;
  lum_coef_t   coef_q;
  logic [31:0] cx, cy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q   <= FocalRst;
      fy_q   <= FocalRst;
      pp_q   <= PrincipalRst;
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (lum_reg_e'(cfg_idx_i))
        REG_FOCAL_X:      fx_q      <= cfg_data_i[31:0];
        REG_FOCAL_Y:      fy_q      <= cfg_data_i[31:0];
        REG_PRINCIPAL:    pp_q      <= cfg_data_i;
        REG_RADIAL_1:     coef_q.k1 <= $signed(cfg_data_i[31:0]);
        REG_RADIAL_2:     coef_q.k2 <= $signed(cfg_data_i[31:0]);
        REG_RADIAL_3:     coef_q.k3 <= $signed(cfg_data_i[31:0]);
        REG_TANGENTIAL_1: coef_q.p1 <= $signed(cfg_data_i[31:0]);
        REG_TANGENTIAL_2: coef_q.p2 <= $signed(cfg_data_i[31:0]);
        default: ;
      endcase
    end
  end

  assign cx = pp_q[31:0];
  assign cy = pp_q[63:32];

  // Global advance: the pipeline moves unless the skid stage is occupied
  logic en;
  logic skid_valid_q;
  assign en          = !skid_valid_q;
  assign pix_stall_o = !en;

  // Normalization numerators: |(p<<16) - c| << 28 + f/2
  logic [11:0]        col_c, row_c;
  logic signed [33:0] nx, ny;
  logic [32:0]        mx, my;
  logic [61:0]        numx, numy;

  always_comb begin
    col_c = ({5'd0, pixel_col_i} > SideMax) ? SideMax[11:0] : pixel_col_i;
    row_c = ({5'd0, pixel_row_i} > SideMax) ? SideMax[11:0] : pixel_row_i;
    nx    = $signed({6'd0, col_c, 16'd0}) - $signed({2'b00, cx});
    ny    = $signed({6'd0, row_c, 16'd0}) - $signed({2'b00, cy});
    mx    = nx[33] ? 33'(-nx) : nx[32:0];
    my    = ny[33] ? 33'(-ny) : ny[32:0];
    numx  = {1'b0, mx, 28'd0} + 62'(fx_q[31:1]);
    numy  = {1'b0, my, 28'd0} + 62'(fy_q[31:1]);
  end

  logic               nv_x, nv_y;
  logic signed [31:0] x0, y0;

  lum_divider u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_valid_i),
    .num_i   (numx),
    .den_i   (fx_q),
    .neg_i   (nx[33]),
    .valid_o (nv_x),
    .quo_o   (x0)
  );

  lum_divider u_norm_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_valid_i),
    .num_i   (numy),
    .den_i   (fy_q),
    .neg_i   (ny[33]),
    .valid_o (nv_y),
    .quo_o   (y0)
  );

  // Iteration chain
  logic               it_v  [ITERATIONS+1];
  logic signed [31:0] it_x  [ITERATIONS+1];
  logic signed [31:0] it_y  [ITERATIONS+1];
  logic signed [31:0] it_x0 [ITERATIONS+1];
  logic signed [31:0] it_y0 [ITERATIONS+1];

  assign it_v[0]  = nv_x;
  assign it_x[0]  = x0;
  assign it_y[0]  = y0;
  assign it_x0[0] = x0;
  assign it_y0[0] = y0;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    lum_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .coef_i  (coef_q),
      .valid_i (it_v[i]),
      .x_i     (it_x[i]),
      .y_i     (it_y[i]),
      .x0_i    (it_x0[i]),
      .y0_i    (it_y0[i]),
      .valid_o (it_v[i+1]),
      .x_o     (it_x[i+1]),
      .y_o     (it_y[i+1]),
      .x0_o    (it_x0[i+1]),
      .y0_o    (it_y0[i+1])
    );
  end

  // Projection products
  logic               pr_v_q;
  logic signed [64:0] prx_q, pry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (en) begin
      pr_v_q <= it_v[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q <= it_x[ITERATIONS] * $signed({1'b0, fx_q});
      pry_q <= it_y[ITERATIONS] * $signed({1'b0, fy_q});
    end
  end

  // Round, add principal point, saturate
  logic signed [31:0] col_res, row_res;

  always_comb begin
    col_res = sat32(40'(prx_q >>> 28) + $signed({39'd0, prx_q[27]})
                    + $signed({8'd0, cx}));
    row_res = sat32(40'(pry_q >>> 28) + $signed({39'd0, pry_q[27]})
                    + $signed({8'd0, cy}));
  end

  // Output register with skid stage
  logic               out_valid_q;
  logic signed [31:0] out_col_q, out_row_q, skid_col_q, skid_row_q;
  logic               take, load_out, load_skid, from_skid;

  assign take      = out_valid_q && !map_stall_i;
  assign load_out  = en && pr_v_q && (!out_valid_q || take);
  assign load_skid = en && pr_v_q && out_valid_q && !take;
  assign from_skid = skid_valid_q && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (load_out || from_skid) begin
        out_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
      if (load_skid) begin
        skid_valid_q <= 1'b1;
      end else if (from_skid) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_col_q <= skid_col_q;
      out_row_q <= skid_row_q;
    end else if (load_out) begin
      out_col_q <= col_res;
      out_row_q <= row_res;
    end
    if (load_skid) begin
      skid_col_q <= col_res;
      skid_row_q <= row_res;
    end
  end

  assign map_valid_o = out_valid_q;
  assign map_col_o   = out_col_q;
  assign map_row_o   = out_row_q;

  // Both normalization lanes run in lockstep
  a_norm_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nv_x == nv_y) else $error("normalization lanes out of step");

  // The skid stage is only occupied behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid full with empty output");

  // The skid stage fills only when the output is stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && map_stall_i))
    else $error("skid filled without stall");

  // A taken output empties the skid stage in the following cycle
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !map_stall_i |=> !skid_valid_q)
    else $error("skid not drained");

endmodule

/* bench/lens_undistort_map_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_undistort_map_tb
// Self-checking bench for the lens undistortion map. A local fixed-point
// model predicts each map position; results are compared in order under
// several idle/stall mixes, several register settings and one long hold-off.
// ----------------------------------------------------------------------------
module lens_undistort_map_tb;
  import lum_pkg::*;

  localparam int unsigned PipeLat = 37 + 41 * IterationsDef;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [63:0]        cfg_data_i;
  logic               pix_valid_i;
  logic               pix_stall_o;
  logic [11:0]        pixel_col_i;
  logic [11:0]        pixel_row_i;
  logic               map_valid_o;
  logic               map_stall_i;
  logic signed [31:0] map_col_o;
  logic signed [31:0] map_row_o;

  // local copy of the registers
  logic [31:0]        fx_q, fy_q;
  logic [63:0]        pp_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  logic signed [31:0] exp_col_q[$];
  logic signed [31:0] exp_row_q[$];
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 holdoff_cycles;
  bit                 failed;

  lens_undistort_map i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------- fixed-point model ----------------
  function automatic longint s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // arithmetic shift right by 28 with round half up
  function automatic longint rnd28(longint v);
    return (v >>> 28) + ((v >>> 27) & 1);
  endfunction

  function automatic longint qm(longint a, longint b);
    return s32(rnd28(a * b));
  endfunction

  function automatic longint norm_q28(longint n, longint unsigned d);
    longint unsigned mag, q;
    if (d == 0) return n >= 0 ? 64'sd2147483647 : -64'sd2147483648;
    mag = longint'(n < 0 ? -n : n) << 28;
    q = (mag + d / 2) / d;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return s32(n < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint recip_q28(longint den);
    longint unsigned d, q;
    if (den == 0) return 64'sd2147483647;
    d = den < 0 ? -den : den;
    q = ((64'd1 << 56) + d / 2) / d;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return s32(den < 0 ? -longint'(q) : longint'(q));
  endfunction

  task automatic predict_map(input logic [11:0] col, input logic [11:0] row);
    longint cx, cy, x0, y0, x, y, xx, yy, xy, r2, poly, ic, dx, dy;
    cx = pp_q[31:0];
    cy = pp_q[63:32];
    x0 = norm_q28((longint'(col) << 16) - cx, fx_q);
    y0 = norm_q28((longint'(row) << 16) - cy, fy_q);
    x = x0;
    y = y0;
    for (int it = 0; it < IterationsDef; it++) begin
      xx = qm(x, x);
      yy = qm(y, y);
      xy = qm(x, y);
      r2 = s32(xx + yy);
      poly = s32(qm(k3_q, r2) + k2_q);
      poly = s32(qm(poly, r2) + k1_q);
      poly = qm(poly, r2);
      ic = recip_q28(s32(64'sd268435456 + poly));
      dx = s32(s32(2 * qm(p1_q, xy)) + qm(p2_q, s32(r2 + s32(2 * xx))));
      dy = s32(qm(p1_q, s32(r2 + s32(2 * yy))) + s32(2 * qm(p2_q, xy)));
      x = qm(s32(x0 - dx), ic);
      y = qm(s32(y0 - dy), ic);
    end
    exp_col_q.push_back(32'(s32(rnd28(x * longint'(fx_q)) + cx)));
    exp_row_q.push_back(32'(s32(rnd28(y * longint'(fy_q)) + cy)));
  endtask

  // ---------------- drivers ----------------
  task automatic write_reg(input lum_reg_e idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_FOCAL_X:      fx_q = data[31:0];
      REG_FOCAL_Y:      fy_q = data[31:0];
      REG_PRINCIPAL:    pp_q = data;
      REG_RADIAL_1:     k1_q = data[31:0];
      REG_RADIAL_2:     k2_q = data[31:0];
      REG_RADIAL_3:     k3_q = data[31:0];
      REG_TANGENTIAL_1: p1_q = data[31:0];
      REG_TANGENTIAL_2: p2_q = data[31:0];
      default: ;
    endcase
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays up after the accept; the next send or drain sets it
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pix_valid_i <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    @(posedge clk_i);
    while (pix_stall_o) @(posedge clk_i);
    predict_map(col, row);
  endtask

  task automatic drain;
    pix_valid_i <= 1'b0;
    while (exp_col_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 10) @(posedge clk_i);
  endtask

  task automatic set_coefs(input logic [31:0] k1, k2, k3, p1, p2);
    write_reg(REG_RADIAL_1, {32'd0, k1});
    write_reg(REG_RADIAL_2, {32'd0, k2});
    write_reg(REG_RADIAL_3, {32'd0, k3});
    write_reg(REG_TANGENTIAL_1, {32'd0, p1});
    write_reg(REG_TANGENTIAL_2, {32'd0, p2});
  endtask

  task automatic random_pixels(input int n);
    logic [11:0] c, r;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(9) == 0 ? 12'hFFF : 12'($urandom_range(4095));
      r = $urandom_range(9) == 0 ? 12'h000 : 12'($urandom_range(4095));
      send_pixel(c, r);
    end
  endtask

  // ---------------- result checker ----------------
  initial begin
    map_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (map_valid_o && !map_stall_i) begin
        if (exp_col_q.size() == 0) begin
          $display("%0t: unexpected map transaction col=%0d row=%0d",
                   $time, map_col_o, map_row_o);
          failed = 1'b1;
        end else begin
          if (map_col_o !== exp_col_q[0]) begin
            $display("%0t: map_col expected %0d actual %0d",
                     $time, exp_col_q[0], map_col_o);
            failed = 1'b1;
          end
          if (map_row_o !== exp_row_q[0]) begin
            $display("%0t: map_row expected %0d actual %0d",
                     $time, exp_row_q[0], map_row_o);
            failed = 1'b1;
          end
          void'(exp_col_q.pop_front());
          void'(exp_row_q.pop_front());
        end
      end
      if (holdoff_cycles > 0) begin
        holdoff_cycles--;
        map_stall_i <= 1'b1;
      end else begin
        map_stall_i <= $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();
    // strong barrel/pincushion coefficients and extremes
    set_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd320, 12'd240);
    drain();
    // denominator zero at r2=1: k1 = -1, tiny focal saturates coordinates
    set_coefs(32'hF000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
    write_reg(REG_FOCAL_X, 64'd65536);
    write_reg(REG_FOCAL_Y, 64'd65536);
    write_reg(REG_PRINCIPAL, {32'd0, 32'd65536});
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    // zero focal lengths, top principal point
    write_reg(REG_FOCAL_X, 64'd0);
    write_reg(REG_FOCAL_Y, 64'd0);
    write_reg(REG_PRINCIPAL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    write_reg(REG_FOCAL_X, 64'hFFFF_FFFF);
    write_reg(REG_FOCAL_Y, 64'hFFFF_FFFF);
    write_reg(REG_PRINCIPAL, 64'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    drain();
  endtask

  task automatic test_random_settings;
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      write_reg(REG_FOCAL_X, {32'd0, 32'($urandom_range(32'h0400_0000, 32'h0010_0000))});
      write_reg(REG_FOCAL_Y, {32'd0, 32'($urandom_range(32'h0400_0000, 32'h0010_0000))});
      write_reg(REG_PRINCIPAL, {4'd0, 28'($urandom), 4'd0, 28'($urandom)});
      set_coefs($urandom >>> 2, $urandom >>> 4, $urandom >>> 6,
                $urandom >>> 6, $urandom >>> 6);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      random_pixels(90);
      drain();
    end
  endtask

  // more pixels than the pipeline holds, so the input stalls
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 800;
    random_pixels(300);
    drain();
  endtask

  initial begin
    failed = 1'b0;
    holdoff_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FOCAL_X;
    cfg_data_i = '0;
    pix_valid_i = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    fx_q = FocalRst;
    fy_q = FocalRst;
    pp_q = PrincipalRst;
    {k1_q, k2_q, k3_q, p1_q, p2_q} = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* lens_undistort_map.f */
hw/rtl/lum_pkg.sv
hw/rtl/lum_div_cell.sv
hw/rtl/lum_divider.sv
hw/rtl/lum_iter.sv
hw/rtl/lens_undistort_map.sv
bench/lens_undistort_map_tb.sv
